// File: rtl/svpwm_pkg.sv
// shared constants and helpers for the svpwm sector and compare block
// no dependencies
package svpwm_pkg;

  // timer counter width, compares saturate at its full scale
  localparam int CNT_W = 16;

  localparam int VOLT_W = 24;  // alpha / beta input width
  localparam int CMP_W  = 17;  // compare output width
  localparam int CFG_W  = 23;  // widest config register

  // sqrt(3) in Q20
  localparam logic signed [21:0] SQ3_Q20 = 22'sd1816187;

  // saturation cap of one compare
  localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'((64'd1 << CNT_W) - 64'd1);

  // largest limit fraction, 1.0 in Q1.16
  localparam logic [16:0] LIM_ONE = 17'd65536;

  // config register indexes
  typedef enum logic [7:0] {
    CFG_PWM_PERIOD  = 8'd0,
    CFG_BUS_VOLTAGE = 8'd1,
    CFG_MOD_LIMIT   = 8'd2,
    CFG_DEADTIME    = 8'd3
  } cfg_idx_t;

  // sector codes from the three sign tests
  typedef enum logic [2:0] {
    CODE_NONE0 = 3'd0,
    CODE_S2    = 3'd1,
    CODE_S6    = 3'd2,
    CODE_S1    = 3'd3,
    CODE_S4    = 3'd4,
    CODE_S3    = 3'd5,
    CODE_S5    = 3'd6,
    CODE_NONE7 = 3'd7
  } code_t;

  // raw code to sector number
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] s;
    unique case (code_t'(code))
      CODE_S1: s = 3'd1;
      CODE_S2: s = 3'd2;
      CODE_S3: s = 3'd3;
      CODE_S4: s = 3'd4;
      CODE_S5: s = 3'd5;
      CODE_S6: s = 3'd6;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/svpwm_sector_and_compare.sv
// svpwm sector decision and seven-segment compare values, fully pipelined
// throughput one request per cycle while no result is held at the output
// the active-time divide runs as a 32-stage restoring pipeline, the limit rescale
// as a 17-stage one; a held result stalls the whole pipeline, nothing is dropped
// reset: synchronous active-low rst_n clears all valid bits and loads config defaults
// depends on svpwm_pkg
module svpwm_sector_and_compare
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // alpha_volts[23:0], beta_volts[47:24]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // sector_number[2:0], sector_code[5:3], compare_phase_a[22:6],
  // compare_phase_b[39:23], compare_phase_c[56:40], overmod_limited[57], zero[63:58]
  output logic [63:0] out_tdata,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  localparam int D1_N = 32;   // active time quotient bits
  localparam int D2_N = 17;   // rescaled time quotient bits

  // ---------------------------------------------------------------- config
  logic [15:0] per_r;
  logic [22:0] bus_r;
  logic [16:0] mlim_r;
  logic [7:0]  dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r  <= 16'd4200;
      bus_r  <= 23'd1572864;
      mlim_r <= LIM_ONE;
      dead_r <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PWM_PERIOD:  per_r  <= cfg_data[15:0];
        CFG_BUS_VOLTAGE: bus_r  <= cfg_data;
        CFG_MOD_LIMIT:   mlim_r <= cfg_data[16:0];
        CFG_DEADTIME:    dead_r <= cfg_data[7:0];
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // derived config, refreshed every cycle: divisor 3*udc and the limit in counts
  logic [22:0] udc;
  logic [16:0] lm;
  logic [32:0] lim_prod;
  logic [24:0] d3_r;
  logic [16:0] lim_r;

  always_comb begin
    udc      = (bus_r == 23'd0) ? 23'd1 : bus_r;
    lm       = (mlim_r > LIM_ONE) ? LIM_ONE : mlim_r;
    lim_prod = 33'(per_r) * 33'(lm);
  end

  always_ff @(posedge clk) begin
    d3_r  <= {1'b0, udc, 1'b0} + 25'(udc);
    lim_r <= lim_prod[32:16];
  end

  // one enable for every stage: the pipeline moves unless a result is held
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- stage 1
  // sqrt3 products of both axes
  logic               s1_v_r;
  logic signed [23:0] s1_al_r, s1_be_r;
  logic signed [45:0] s1_sa_r, s1_sb_r;

  // ---------------------------------------------------------------- stage 2
  // sign tests, X/Y/Z numerators, pick the two active numerators by code
  logic               s2_v_r;
  logic [2:0]         s2_code_r;
  logic [46:0]        s2_m_r [2];
  logic signed [47:0] b_t, c_t, al3, nx, ny, nz, n4, n6;
  logic [2:0]         code_nxt;

  always_comb begin
    b_t = 48'(s1_sa_r) - (48'(s1_be_r) <<< 20);
    c_t = -48'(s1_sa_r) - (48'(s1_be_r) <<< 20);
    code_nxt = {c_t > 48'sd0, b_t > 48'sd0, s1_be_r > 24'sd0};
    al3 = (48'(s1_al_r) <<< 1) + 48'(s1_al_r);
    nx  = 48'(s1_sb_r) <<< 1;
    ny  = (al3 <<< 20) + 48'(s1_sb_r);
    nz  = 48'(s1_sb_r) - (al3 <<< 20);
    case (code_t'(code_nxt))
      CODE_S2: begin n4 = nz;  n6 = ny;  end
      CODE_S6: begin n4 = ny;  n6 = -nx; end
      CODE_S1: begin n4 = -nz; n6 = nx;  end
      CODE_S4: begin n4 = -nx; n6 = nz;  end
      CODE_S3: begin n4 = nx;  n6 = -ny; end
      CODE_S5: begin n4 = -ny; n6 = -nz; end
      default: begin n4 = '0;  n6 = '0;  end
    endcase
  end

  // ---------------------------------------------------------------- stage 3
  // period times numerator, split in 16x24 and 16x23 partial products per lane
  logic        s3_v_r;
  logic [2:0]  s3_code_r;
  logic [39:0] s3_pl_r [2];
  logic [38:0] s3_ph_r [2];

  // ---------------------------------------------------------------- stage 4
  // full product, drop the Q20 scale, saturation check against 3*udc*2^32
  logic        s4_v_r;
  logic [2:0]  s4_code_r;
  logic [42:0] s4_q_r [2];
  logic [62:0] prod [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l] = (63'(s3_ph_r[l]) << 24) + 63'(s3_pl_r[l]);
    end
  end

  // ---------------------------------------------------------------- divider 1
  // restoring divide by 3*udc, one quotient bit per stage
  logic        d1_v_r    [D1_N];
  logic [2:0]  d1_code_r [D1_N];
  logic        d1_sat_r  [D1_N][2];
  logic [24:0] d1_rem_r  [D1_N][2];
  logic [31:0] d1_q_r    [D1_N][2];
  logic [24:0] d1_rem_nxt [D1_N][2];
  logic [31:0] d1_q_nxt   [D1_N][2];
  logic        d1_sat0    [2];

  always_comb begin
    logic [24:0] src_rem;
    logic [31:0] src_q;
    logic [25:0] tmp;
    for (int l = 0; l < 2; l++) begin
      d1_sat0[l] = 25'(s4_q_r[l][42:32]) >= d3_r;
    end
    for (int k = 0; k < D1_N; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          src_rem = 25'(s4_q_r[l][42:32]);
          src_q   = s4_q_r[l][31:0];
        end else begin
          src_rem = d1_rem_r[k-1][l];
          src_q   = d1_q_r[k-1][l];
        end
        tmp = {src_rem, src_q[31]};
        if (tmp >= {1'b0, d3_r}) begin
          d1_rem_nxt[k][l] = 25'(tmp - {1'b0, d3_r});
          d1_q_nxt[k][l]   = {src_q[30:0], 1'b1};
        end else begin
          d1_rem_nxt[k][l] = tmp[24:0];
          d1_q_nxt[k][l]   = {src_q[30:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  // clamp, sum of active times, limit test
  logic        s5_v_r;
  logic [2:0]  s5_code_r;
  logic [31:0] s5_t_r [2];
  logic [32:0] s5_sum_r;
  logic        s5_lim_r;
  logic [31:0] t_clip [2];
  logic [32:0] sum_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t_clip[l] = d1_sat_r[D1_N-1][l] ? 32'hFFFF_FFFF : d1_q_r[D1_N-1][l];
    end
    sum_nxt = 33'(t_clip[0]) + 33'(t_clip[1]);
  end

  // ---------------------------------------------------------------- stage 6
  // rescale numerators t*lim over sum; an unlimited time passes as t / 1
  logic        s6_v_r;
  logic [2:0]  s6_code_r;
  logic        s6_lim_r;
  logic [32:0] s6_div_r;
  logic [47:0] s6_num_r [2];
  logic [48:0] tl_prod [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      tl_prod[l] = 49'(s5_t_r[l]) * 49'(lim_r);
    end
  end

  // ---------------------------------------------------------------- divider 2
  logic        d2_v_r    [D2_N];
  logic [2:0]  d2_code_r [D2_N];
  logic        d2_lim_r  [D2_N];
  logic [32:0] d2_div_r  [D2_N];
  logic [32:0] d2_rem_r  [D2_N][2];
  logic [16:0] d2_q_r    [D2_N][2];
  logic [32:0] d2_rem_nxt [D2_N][2];
  logic [16:0] d2_q_nxt   [D2_N][2];
  logic [32:0] d2_div_src [D2_N];

  always_comb begin
    logic [32:0] src_rem;
    logic [16:0] src_q;
    logic [33:0] tmp;
    for (int k = 0; k < D2_N; k++) begin
      d2_div_src[k] = (k == 0) ? s6_div_r : d2_div_r[k-1];
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          src_rem = 33'(s6_num_r[l][47:17]);
          src_q   = s6_num_r[l][16:0];
        end else begin
          src_rem = d2_rem_r[k-1][l];
          src_q   = d2_q_r[k-1][l];
        end
        tmp = {src_rem, src_q[16]};
        if (tmp >= {1'b0, d2_div_src[k]}) begin
          d2_rem_nxt[k][l] = 33'(tmp - {1'b0, d2_div_src[k]});
          d2_q_nxt[k][l]   = {src_q[15:0], 1'b1};
        end else begin
          d2_rem_nxt[k][l] = tmp[32:0];
          d2_q_nxt[k][l]   = {src_q[15:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 7
  // seven-segment times ta, tb, tc
  logic        s7_v_r;
  logic [2:0]  s7_code_r;
  logic        s7_lim_r;
  logic [16:0] s7_ta_r, s7_tb_r, s7_tc_r;
  logic [16:0] t4f, t6f, ta_nxt, tb_nxt;
  logic [17:0] zero_t;

  always_comb begin
    t4f    = d2_q_r[D2_N-1][0];
    t6f    = d2_q_r[D2_N-1][1];
    zero_t = 18'(per_r) - 18'(t4f) - 18'(t6f);
    ta_nxt = 17'(zero_t[17:2]);
    tb_nxt = ta_nxt + (t4f >> 1);
  end

  // ---------------------------------------------------------------- output
  // phase assignment by code, dead-time offset, saturation to counter scale
  logic        out_v_r;
  logic [63:0] out_data_r;
  logic [16:0] pa, pb, pc;
  logic [17:0] ca, cb, cc;
  logic [16:0] cmp_a, cmp_b, cmp_c;
  logic        flag_nxt;

  always_comb begin
    flag_nxt = s7_lim_r;
    case (code_t'(s7_code_r))
      CODE_S2: begin pa = s7_tb_r; pb = s7_ta_r; pc = s7_tc_r; end
      CODE_S6: begin pa = s7_ta_r; pb = s7_tc_r; pc = s7_tb_r; end
      CODE_S1: begin pa = s7_ta_r; pb = s7_tb_r; pc = s7_tc_r; end
      CODE_S4: begin pa = s7_tc_r; pb = s7_tb_r; pc = s7_ta_r; end
      CODE_S3: begin pa = s7_tc_r; pb = s7_ta_r; pc = s7_tb_r; end
      CODE_S5: begin pa = s7_tb_r; pb = s7_tc_r; pc = s7_ta_r; end
      default: begin
        // zero vector codes: offset only, never flagged
        pa = '0; pb = '0; pc = '0;
        flag_nxt = 1'b0;
      end
    endcase
    ca = 18'(pa) + 18'(dead_r);
    cb = 18'(pb) + 18'(dead_r);
    cc = 18'(pc) + 18'(dead_r);
    cmp_a = (ca > 18'(CMP_MAX)) ? CMP_MAX : ca[16:0];
    cmp_b = (cb > 18'(CMP_MAX)) ? CMP_MAX : cb[16:0];
    cmp_c = (cc > 18'(CMP_MAX)) ? CMP_MAX : cc[16:0];
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < D1_N; k++) d1_v_r[k] <= 1'b0;
      for (int k = 0; k < D2_N; k++) d2_v_r[k] <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      d1_v_r[0] <= s4_v_r;
      for (int k = 1; k < D1_N; k++) d1_v_r[k] <= d1_v_r[k-1];
      s5_v_r <= d1_v_r[D1_N-1];
      s6_v_r <= s5_v_r;
      d2_v_r[0] <= s6_v_r;
      for (int k = 1; k < D2_N; k++) d2_v_r[k] <= d2_v_r[k-1];
      s7_v_r  <= d2_v_r[D2_N-1];
      out_v_r <= s7_v_r;
    end
  end

  // ---------------------------------------------------------------- data path
  always_ff @(posedge clk) begin
    if (en) begin
      s1_al_r <= signed'(in_tdata[23:0]);
      s1_be_r <= signed'(in_tdata[47:24]);
      s1_sa_r <= 46'(SQ3_Q20) * 46'(signed'(in_tdata[23:0]));
      s1_sb_r <= 46'(SQ3_Q20) * 46'(signed'(in_tdata[47:24]));

      s2_code_r <= code_nxt;
      s2_m_r[0] <= (n4 > 48'sd0) ? n4[46:0] : '0;
      s2_m_r[1] <= (n6 > 48'sd0) ? n6[46:0] : '0;

      s3_code_r <= s2_code_r;
      for (int l = 0; l < 2; l++) begin
        s3_pl_r[l] <= 40'(per_r) * 40'(s2_m_r[l][23:0]);
        s3_ph_r[l] <= 39'(per_r) * 39'(s2_m_r[l][46:24]);
      end

      s4_code_r <= s3_code_r;
      for (int l = 0; l < 2; l++) s4_q_r[l] <= prod[l][62:20];

      d1_code_r[0] <= s4_code_r;
      for (int l = 0; l < 2; l++) d1_sat_r[0][l] <= d1_sat0[l];
      for (int k = 1; k < D1_N; k++) begin
        d1_code_r[k] <= d1_code_r[k-1];
        for (int l = 0; l < 2; l++) d1_sat_r[k][l] <= d1_sat_r[k-1][l];
      end
      for (int k = 0; k < D1_N; k++) begin
        for (int l = 0; l < 2; l++) begin
          d1_rem_r[k][l] <= d1_rem_nxt[k][l];
          d1_q_r[k][l]   <= d1_q_nxt[k][l];
        end
      end

      s5_code_r <= d1_code_r[D1_N-1];
      s5_t_r[0] <= t_clip[0];
      s5_t_r[1] <= t_clip[1];
      s5_sum_r  <= sum_nxt;
      s5_lim_r  <= sum_nxt > 33'(lim_r);

      s6_code_r <= s5_code_r;
      s6_lim_r  <= s5_lim_r;
      s6_div_r  <= s5_lim_r ? s5_sum_r : 33'd1;
      for (int l = 0; l < 2; l++) begin
        s6_num_r[l] <= s5_lim_r ? tl_prod[l][47:0] : 48'(s5_t_r[l]);
      end

      d2_code_r[0] <= s6_code_r;
      d2_lim_r[0]  <= s6_lim_r;
      for (int k = 1; k < D2_N; k++) begin
        d2_code_r[k] <= d2_code_r[k-1];
        d2_lim_r[k]  <= d2_lim_r[k-1];
      end
      for (int k = 0; k < D2_N; k++) begin
        d2_div_r[k] <= d2_div_src[k];
        for (int l = 0; l < 2; l++) begin
          d2_rem_r[k][l] <= d2_rem_nxt[k][l];
          d2_q_r[k][l]   <= d2_q_nxt[k][l];
        end
      end

      s7_code_r <= d2_code_r[D2_N-1];
      s7_lim_r  <= d2_lim_r[D2_N-1];
      s7_ta_r   <= ta_nxt;
      s7_tb_r   <= tb_nxt;
      s7_tc_r   <= tb_nxt + (t6f >> 1);

      out_data_r <= {6'd0, flag_nxt, cmp_c, cmp_b, cmp_a, s7_code_r,
                     sector_of_code(s7_code_r)};
    end
  end

endmodule

// File: tb/svpwm_checker.sv
`timescale 1ns / 1ps
// result checker for svpwm_sector_and_compare: tracks config writes, predicts each result
// from the accepted alpha/beta request and compares it field by field; depends on svpwm_pkg
module svpwm_checker
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [22:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          limited_seen
);

  localparam longint ONE_Q20  = 64'sd1048576;
  localparam longint TIME_CAP = 64'sd4294967295;

  logic [15:0] period_r;
  logic [22:0] bus_r;
  logic [16:0] limit_r;
  logic [7:0]  dead_r;

  logic [63:0] expected_results[$];

  function automatic longint on_time(longint per, longint num, longint den);
    longint t;
    t = (per * num) / den;
    if (t < 0) t = 0;
    if (t > TIME_CAP) t = TIME_CAP;
    return t;
  endfunction

  function automatic logic [CMP_W-1:0] with_deadtime(longint t);
    longint v;
    v = t + longint'(dead_r);
    if (v > longint'(CMP_MAX)) v = longint'(CMP_MAX);
    return CMP_W'(v);
  endfunction

  function automatic logic [63:0] compute_compares(logic [47:0] d);
    longint al, be, per, udc, den, sq3, nx, ny, nz, n4, n6, t4, t6, lim, sum, ta, tb, tc, lm;
    longint ph[3];
    logic [2:0] code, sector;
    logic flag;
    al = longint'($signed(d[23:0]));
    be = longint'($signed(d[47:24]));
    sq3 = longint'(SQ3_Q20);
    per = longint'(period_r);
    udc = (bus_r == 0) ? 1 : longint'(bus_r);
    den = 3 * udc * ONE_Q20;
    lm = (limit_r > LIM_ONE) ? longint'(LIM_ONE) : longint'(limit_r);
    code = 3'd0;
    flag = 1'b0;
    n4 = 0;
    n6 = 0;
    ph[0] = 0; ph[1] = 0; ph[2] = 0;
    if (be > 0) code[0] = 1'b1;
    if (sq3 * al - ONE_Q20 * be > 0) code[1] = 1'b1;
    if (-sq3 * al - ONE_Q20 * be > 0) code[2] = 1'b1;
    nx = 2 * sq3 * be;
    ny = 3 * ONE_Q20 * al + sq3 * be;
    nz = -3 * ONE_Q20 * al + sq3 * be;
    case (code_t'(code))
      CODE_S2: begin n4 = nz;  n6 = ny;  sector = 3'd2; end
      CODE_S6: begin n4 = ny;  n6 = -nx; sector = 3'd6; end
      CODE_S1: begin n4 = -nz; n6 = nx;  sector = 3'd1; end
      CODE_S4: begin n4 = -nx; n6 = nz;  sector = 3'd4; end
      CODE_S3: begin n4 = nx;  n6 = -ny; sector = 3'd3; end
      CODE_S5: begin n4 = -ny; n6 = -nz; sector = 3'd5; end
      default: sector = 3'd0;
    endcase
    if (sector != 3'd0) begin
      t4 = on_time(per, n4, den);
      t6 = on_time(per, n6, den);
      lim = (per * lm) >>> 16;
      if (t4 + t6 > lim) begin
        sum = t4 + t6;
        t4 = (t4 * lim) / sum;
        t6 = (t6 * lim) / sum;
        flag = 1'b1;
      end
      ta = (per - t4 - t6) / 4;
      tb = ta + t4 / 2;
      tc = tb + t6 / 2;
      case (code_t'(code))
        CODE_S2: begin ph[0] = tb; ph[1] = ta; ph[2] = tc; end
        CODE_S6: begin ph[0] = ta; ph[1] = tc; ph[2] = tb; end
        CODE_S1: begin ph[0] = ta; ph[1] = tb; ph[2] = tc; end
        CODE_S4: begin ph[0] = tc; ph[1] = tb; ph[2] = ta; end
        CODE_S3: begin ph[0] = tc; ph[1] = ta; ph[2] = tb; end
        default: begin ph[0] = tb; ph[1] = tc; ph[2] = ta; end
      endcase
    end
    return {6'd0, flag, with_deadtime(ph[2]), with_deadtime(ph[1]), with_deadtime(ph[0]),
            code, sector};
  endfunction

  // one field of a packed result, low bit first order
  function automatic logic [16:0] field_of(logic [63:0] r, int f);
    case (f)
      0: return 17'(r[2:0]);
      1: return 17'(r[5:3]);
      2: return r[22:6];
      3: return r[39:23];
      4: return r[56:40];
      default: return 17'(r[57]);
    endcase
  endfunction

  string field_names[6] = '{"sector_number", "sector_code", "compare_phase_a",
                            "compare_phase_b", "compare_phase_c", "overmod_limited"};

  always @(posedge clk) begin
    logic [63:0] exp_r;
    if (!rst_n) begin
      period_r <= 16'd4200;
      bus_r <= 23'd1572864;
      limit_r <= 17'd65536;
      dead_r <= 8'd4;
      expected_results.delete();
      fail_count <= 0;
      pending <= 0;
      results_seen <= 0;
      limited_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PWM_PERIOD:  period_r <= cfg_data[15:0];
          CFG_BUS_VOLTAGE: bus_r <= cfg_data;
          CFG_MOD_LIMIT:   limit_r <= cfg_data[16:0];
          CFG_DEADTIME:    dead_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_results.push_back(compute_compares(in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (out_tdata[57]) limited_seen <= limited_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r != out_tdata) begin
            fail_count <= fail_count + 1;
            for (int f = 0; f < 6; f++)
              if (field_of(exp_r, f) != field_of(out_tdata, f))
                $display("%0t: %s expected %0d actual %0d", $time, field_names[f],
                         field_of(exp_r, f), field_of(out_tdata, f));
            if (exp_r[63:58] != out_tdata[63:58])
              $display("%0t: pad bits expected %h actual %h", $time, exp_r[63:58],
                       out_tdata[63:58]);
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for svpwm_sector_and_compare: clock, reset, request stimulus and verdict
// depends on svpwm_pkg, the block and tb/svpwm_checker.sv
module tb_top;
  import svpwm_pkg::*;

  // index past the register list, the block must ignore it
  localparam logic [7:0] CFG_NO_SUCH_REG = 8'd200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 70;  // longer than the pipeline from request to result

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;    // alpha_volts[23:0], beta_volts[47:24]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // sector_number, sector_code, compares a b c, overmod flag
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [22:0] cfg_data = '0;

  int fail_count, pending, results_seen, limited_seen;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  logic long_stall_go = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  svpwm_sector_and_compare i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  svpwm_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .results_seen, .limited_seen
  );

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("svpwm_sector_and_compare regression: fail");
      $finish;
    end
  end

  // result side: ready pattern switches periodically to a random mode, plus one long hold-off
  int ready_mode = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (cycles % 97 == 0) ready_mode = $urandom_range(0, 3);
    if (long_stall_go && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // present one request and return at the edge that takes it, valid still high
  task automatic offer_volts(logic [23:0] alpha, logic [23:0] beta);
    in_tvalid <= 1'b1;
    in_tdata <= {beta, alpha};
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    items_sent++;
  endtask

  // sender; when bursty is set, gaps of random length between bursts
  task automatic stream_volts(logic [23:0] alpha, logic [23:0] beta, bit bursty);
    int gap;
    offer_volts(alpha, beta);
    burst_left--;
    if (bursty && burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [22:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every expected result come back
  task automatic settle();
    in_tvalid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(logic [15:0] per, logic [22:0] bus, logic [16:0] lim,
                              logic [7:0] dead);
    write_reg(CFG_PWM_PERIOD, 23'(per));
    write_reg(CFG_BUS_VOLTAGE, bus);
    write_reg(CFG_MOD_LIMIT, 23'(lim));
    write_reg(CFG_DEADTIME, 23'(dead));
  endtask

  // mix of raw bit patterns, the legal span, small realistic values and near zero
  function automatic logic [23:0] pick_volts();
    int mag;
    case ($urandom_range(0, 7))
      0: return 24'($urandom());
      1, 2: return 24'(int'($urandom_range(0, 13107200)) - 6553600);
      3: return 24'(int'($urandom_range(0, 400000)) - 200000);
      4: return 24'(int'($urandom_range(0, 6)) - 3);
      default: begin
        mag = $urandom_range(0, 3000000);
        return ($urandom_range(0, 1) != 0) ? 24'(mag) : 24'(-mag);
      end
    endcase
  endfunction

  logic [23:0] corner_pairs[20][2] = '{
    '{24'd0, 24'd0},
    '{24'd6553600, 24'd0},
    '{-24'sd6553600, 24'd0},
    '{24'd0, 24'd6553600},
    '{24'd0, -24'sd6553600},
    '{24'd6553600, 24'd6553600},
    '{-24'sd6553600, -24'sd6553600},
    '{24'h7FFFFF, 24'h7FFFFF},
    '{24'h800000, 24'h800000},
    '{24'h7FFFFF, 24'h800000},
    '{24'h800000, 24'h7FFFFF},
    '{24'd100000, 24'd100000},      // sector 1
    '{24'd0, 24'd200000},           // sector 2
    '{-24'sd100000, 24'd100000},    // sector 3
    '{-24'sd100000, -24'sd100000},  // sector 4
    '{24'd0, -24'sd200000},         // sector 5
    '{24'd100000, -24'sd100000},    // sector 6
    '{24'd1, 24'd0},                // tiny vector, zero times
    '{24'd60000, 24'd103923},       // near the sector 1 / 2 border
    '{24'hFFFFFF, 24'd1}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under reset defaults
    foreach (corner_pairs[i]) offer_volts(corner_pairs[i][0], corner_pairs[i][1]);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;  // reset defaults
        1: begin
          // shortest period, zero bus voltage, zero limit
          load_setting(16'd4, 23'd0, 17'd0, 8'd0);
          write_reg(CFG_NO_SUCH_REG, 23'h7FFFFF);
        end
        2: load_setting(16'd65535, 23'd65536, 17'd65536, 8'd255);
        3: load_setting(16'd65535, 23'h7FFFFF, 17'h1FFFF, 8'd255);
        4: load_setting(16'd1000, 23'd1572864, 17'd40000, 8'd10);
        default: load_setting(16'($urandom_range(4, 65535)),
                              ($urandom_range(0, 3) == 0) ? 23'($urandom())
                                                          : 23'($urandom_range(65536, 6553600)),
                              17'($urandom_range(0, 131071)), 8'($urandom()));
      endcase
      if (phase == 1) begin
        // the corners again against the odd registers
        foreach (corner_pairs[i]) offer_volts(corner_pairs[i][0], corner_pairs[i][1]);
      end
      if (phase == 4) begin
        // long result hold-off while the sender keeps pushing, fills the pipeline
        long_stall_go <= 1'b1;
        repeat (150) stream_volts(pick_volts(), pick_volts(), 1'b0);
      end
      repeat (phase == 4 ? 80 : 220) stream_volts(pick_volts(), pick_volts(), phase != 6);
      settle();
    end

    $display("sent %0d alpha/beta requests over 8 register settings and directed corners",
             items_sent);
    $display("checked %0d results, %0d of them with the overmodulation limit active",
             results_seen, limited_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("svpwm_sector_and_compare regression: pass");
    end else begin
      $display("svpwm_sector_and_compare regression: fail");
    end
    $finish;
  end

endmodule
